[sv/hbct_pkg.sv]
// hbct_pkg: shared types and constants for the hashed buffer cache tag store
// no dependencies
package hbct_pkg;

    localparam logic [1:0] REQ_GET     = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_PIN     = 2'd2;
    localparam logic [1:0] REQ_UNPIN   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_COUNT    = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    localparam logic [5:0] LINK_NONE   = 6'd63;
    localparam logic [7:0] COUNT_MAX   = 8'd255;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_START_TAG,
        S_SCAN_TAG,
        S_START_FREE,
        S_SCAN_FREE,
        S_START_STEAL,
        S_SCAN_STEAL,
        S_RELINK,
        S_ADJUST,
        S_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;      // latch request fields
        logic hash_step;    // one step of block modulo bucket count
        logic load_head;    // cur <= head of selected bucket
        logic sel_steal;    // bucket select uses steal counter
        logic advance;      // cur <= next_link[cur]
        logic steal_clr;    // steal bucket <= 0
        logic steal_inc;    // steal bucket++
        logic do_hit;       // count++ and mark valid on cur unless count is at max
        logic do_claim;     // claim cur for request
        logic do_relink;    // unlink cur from steal bucket, push on target
        logic do_adjust;    // release, pin or unpin
        logic set_nofree;   // result: no free buffer
        logic out_load;     // present result
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic hash_done;
        logic cur_end;      // cur is end of list or step limit reached
        logic tag_match;
        logic cnt_zero;
        logic steal_last;
        logic is_get;
        logic out_busy;
    } stat_t;

endpackage

[sv/hbct_if.sv]
// hbct_if: valid/ready channel carrying a typed payload
// depends on nothing
interface hbct_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[sv/hbct_ctrl.sv]
// hbct_ctrl: sequencer for get scans, steal walk and count adjustments
// depends on hbct_pkg
module hbct_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  hbct_pkg::stat_t st,
    output hbct_pkg::cmd_t  cmd
);
    hbct_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hbct_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            hbct_pkg::S_IDLE:
            begin
                // take a new request once the previous transaction has left
                in_ready = !st.out_busy;
                if (in_valid && !st.out_busy)
                begin
                    cmd.capture = 1'b1;
                    state_next = hbct_pkg::S_HASH;
                end
            end
            hbct_pkg::S_HASH:
            begin
                if (!st.is_get)
                    state_next = hbct_pkg::S_ADJUST;
                else if (st.hash_done)
                    state_next = hbct_pkg::S_START_TAG;
                else
                    cmd.hash_step = 1'b1;
            end
            hbct_pkg::S_START_TAG:
            begin
                cmd.load_head = 1'b1;
                state_next = hbct_pkg::S_SCAN_TAG;
            end
            hbct_pkg::S_SCAN_TAG:
            begin
                if (st.cur_end)
                    state_next = hbct_pkg::S_START_FREE;
                else if (st.tag_match)
                begin
                    cmd.do_hit = 1'b1;
                    state_next = hbct_pkg::S_DONE;
                end
                else
                    cmd.advance = 1'b1;
            end
            hbct_pkg::S_START_FREE:
            begin
                cmd.load_head = 1'b1;
                state_next = hbct_pkg::S_SCAN_FREE;
            end
            hbct_pkg::S_SCAN_FREE:
            begin
                if (st.cur_end)
                begin
                    cmd.steal_clr = 1'b1;
                    state_next = hbct_pkg::S_START_STEAL;
                end
                else if (st.cnt_zero)
                begin
                    cmd.do_claim = 1'b1;
                    state_next = hbct_pkg::S_DONE;
                end
                else
                    cmd.advance = 1'b1;
            end
            hbct_pkg::S_START_STEAL:
            begin
                cmd.load_head = 1'b1;
                cmd.sel_steal = 1'b1;
                state_next = hbct_pkg::S_SCAN_STEAL;
            end
            hbct_pkg::S_SCAN_STEAL:
            begin
                if (st.cur_end)
                begin
                    if (st.steal_last)
                    begin
                        cmd.set_nofree = 1'b1;
                        state_next = hbct_pkg::S_DONE;
                    end
                    else
                    begin
                        cmd.steal_inc = 1'b1;
                        state_next = hbct_pkg::S_START_STEAL;
                    end
                end
                else if (st.cnt_zero)
                begin
                    cmd.do_claim = 1'b1;
                    state_next = hbct_pkg::S_RELINK;
                end
                else
                    cmd.advance = 1'b1;
            end
            hbct_pkg::S_RELINK:
            begin
                cmd.do_relink = 1'b1;
                state_next = hbct_pkg::S_DONE;
            end
            hbct_pkg::S_ADJUST:
            begin
                cmd.do_adjust = 1'b1;
                state_next = hbct_pkg::S_DONE;
            end
            hbct_pkg::S_DONE:
            begin
                if (!st.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next = hbct_pkg::S_IDLE;
                end
            end
            default:
                state_next = hbct_pkg::S_IDLE;
        endcase
    end
endmodule

[sv/hbct_dp.sv]
// hbct_dp: tag store, bucket lists, counters and result register
// depends on hbct_pkg
module hbct_dp #(
    parameter int NUM_BUFFERS = 32,
    parameter int NUM_BUCKETS = 13
) (
    input  logic            clk,
    input  logic            rst_n,
    input  hbct_pkg::cmd_t  cmd,
    output hbct_pkg::stat_t st,
    input  logic [1:0]      req_type,
    input  logic [7:0]      device_id,
    input  logic [31:0]     block_number,
    input  logic [4:0]      buffer_index,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [4:0]      granted_index,
    output logic            need_read,
    output logic [1:0]      status
);
    localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SW = $clog2(NUM_BUFFERS + 1);
    localparam logic [BW:0] NB_W = NUM_BUCKETS[BW:0];

    // tags, counts and links
    logic [7:0]  tag_dev_reg   [NUM_BUFFERS];
    logic [31:0] tag_blk_reg   [NUM_BUFFERS];
    logic        valid_reg     [NUM_BUFFERS];
    logic [7:0]  cnt_reg       [NUM_BUFFERS];
    logic [5:0]  next_reg      [NUM_BUFFERS];
    logic [5:0]  prev_reg      [NUM_BUFFERS];
    logic [5:0]  first_reg     [NUM_BUCKETS];

    // request and walk registers
    logic [1:0]  req_reg;
    logic [7:0]  dev_reg;
    logic [31:0] blk_reg;
    logic [4:0]  idx_reg;
    logic [BW-1:0] rem_reg;
    logic [BW-1:0] rem_next;
    logic [2:0]  hcnt_reg;
    logic [BW-1:0] bkt_reg;
    logic [BW-1:0] steal_reg;
    logic [5:0]  cur_reg;
    logic [SW-1:0] steps_reg;
    logic [4:0]  res_idx_reg;
    logic        res_need_reg;
    logic [1:0]  res_st_reg;
    logic        out_valid_reg;

    logic [IW-1:0] ci;
    logic          cur_ok;
    logic [BW-1:0] sel_bkt;
    logic [IW-1:0] ai;
    logic          idx_ok;
    logic [7:0]    hbyte;
    logic [BW-1:0] byte_mod;
    logic [BW-1:0] shift_mod;
    logic [BW:0]   mod_sum;

    assign ci     = cur_reg[IW-1:0];
    assign cur_ok = (cur_reg < 6'(NUM_BUFFERS));
    assign sel_bkt = cmd.sel_steal ? steal_reg : bkt_reg;
    assign ai     = IW'(idx_reg);
    assign idx_ok = ({1'b0, idx_reg} < 6'(NUM_BUFFERS));

    // byte of the block number folded in this step, most significant first
    always_comb
    begin
        case (hcnt_reg[1:0])
            2'd0:    hbyte = blk_reg[31:24];
            2'd1:    hbyte = blk_reg[23:16];
            2'd2:    hbyte = blk_reg[15:8];
            default: hbyte = blk_reg[7:0];
        endcase
    end

    // constant residue tables: byte mod buckets, remainder times 256 mod buckets
    always_comb
    begin
        byte_mod = '0;
        shift_mod = '0;
        for (int i = 0; i < 256; i++)
            if (hbyte == 8'(i))
                byte_mod = BW'(i % NUM_BUCKETS);
        for (int r = 0; r < NUM_BUCKETS; r++)
            if (rem_reg == BW'(r))
                shift_mod = BW'((r * 256) % NUM_BUCKETS);
    end

    // both residues are below the bucket count, one subtract brings the sum back
    assign mod_sum  = {1'b0, byte_mod} + {1'b0, shift_mod};
    assign rem_next = (mod_sum >= NB_W) ? BW'(mod_sum - NB_W) : mod_sum[BW-1:0];

    assign st.hash_done  = hcnt_reg[2];
    assign st.cur_end    = !cur_ok || (steps_reg == SW'(NUM_BUFFERS));
    assign st.tag_match  = (tag_dev_reg[ci] == dev_reg) && (tag_blk_reg[ci] == blk_reg);
    assign st.cnt_zero   = (cnt_reg[ci] == 8'd0);
    assign st.steal_last = (steal_reg == BW'(NUM_BUCKETS - 1));
    assign st.is_get     = (req_reg == hbct_pkg::REQ_GET);
    assign st.out_busy   = out_valid_reg && !out_ready;

    assign out_valid     = out_valid_reg;
    assign granted_index = res_idx_reg;
    assign need_read     = res_need_reg;
    assign status        = res_st_reg;

    // request capture, hash and walk pointer
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= req_type;
            dev_reg  <= device_id;
            blk_reg  <= block_number;
            idx_reg  <= buffer_index;
            rem_reg  <= '0;
            hcnt_reg <= '0;
        end
        if (cmd.hash_step)
        begin
            rem_reg  <= rem_next;
            hcnt_reg <= hcnt_reg + 3'd1;
        end
        if (st.hash_done)
            bkt_reg <= rem_reg;
        if (cmd.steal_clr)
            steal_reg <= '0;
        if (cmd.steal_inc)
            steal_reg <= steal_reg + BW'(1);
        if (cmd.load_head)
        begin
            cur_reg   <= first_reg[sel_bkt];
            steps_reg <= '0;
        end
        if (cmd.advance)
        begin
            cur_reg   <= next_reg[ci];
            steps_reg <= steps_reg + SW'(1);
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            res_idx_reg  <= buffer_index;
            res_need_reg <= 1'b0;
            res_st_reg   <= hbct_pkg::ST_OK;
        end
        if (cmd.set_nofree)
        begin
            res_idx_reg <= '0;
            res_st_reg  <= hbct_pkg::ST_NO_FREE;
        end
        if (cmd.do_hit)
        begin
            res_idx_reg <= 5'(cur_reg);
            if (cnt_reg[ci] == hbct_pkg::COUNT_MAX)
                res_st_reg <= hbct_pkg::ST_COUNT;
            else
                res_need_reg <= !valid_reg[ci];
        end
        if (cmd.do_claim)
        begin
            res_idx_reg  <= 5'(cur_reg);
            res_need_reg <= 1'b1;
        end
        if (cmd.do_adjust)
        begin
            if (!idx_ok)
                res_st_reg <= hbct_pkg::ST_RANGE;
            else if (req_reg == hbct_pkg::REQ_PIN && cnt_reg[ai] == hbct_pkg::COUNT_MAX)
                res_st_reg <= hbct_pkg::ST_COUNT;
            else if (req_reg != hbct_pkg::REQ_PIN && cnt_reg[ai] == 8'd0)
                res_st_reg <= hbct_pkg::ST_COUNT;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // tag store and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                tag_dev_reg[i] <= '0;
                tag_blk_reg[i] <= '0;
                valid_reg[i]   <= 1'b0;
                cnt_reg[i]     <= '0;
            end
        end
        else
        begin
            if (cmd.do_hit && cnt_reg[ci] != hbct_pkg::COUNT_MAX)
            begin
                cnt_reg[ci]   <= cnt_reg[ci] + 8'd1;
                valid_reg[ci] <= 1'b1;
            end
            if (cmd.do_claim)
            begin
                tag_dev_reg[ci] <= dev_reg;
                tag_blk_reg[ci] <= blk_reg;
                cnt_reg[ci]     <= 8'd1;
                valid_reg[ci]   <= 1'b1;
            end
            if (cmd.do_adjust && idx_ok)
            begin
                if (req_reg == hbct_pkg::REQ_PIN)
                begin
                    if (cnt_reg[ai] != hbct_pkg::COUNT_MAX)
                        cnt_reg[ai] <= cnt_reg[ai] + 8'd1;
                end
                else if (cnt_reg[ai] != 8'd0)
                    cnt_reg[ai] <= cnt_reg[ai] - 8'd1;
            end
        end
    end

    // bucket lists: unlink from steal bucket, push at head of target
    logic [5:0] rp, rn, th;
    logic       rp_ok, rn_ok;
    assign rp = prev_reg[ci];
    assign rn = next_reg[ci];
    assign rp_ok = (rp < 6'(NUM_BUFFERS));
    assign rn_ok = (rn < 6'(NUM_BUFFERS));
    // head of target after the unlink
    assign th = (!rp_ok && steal_reg == bkt_reg) ? rn : first_reg[bkt_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                next_reg[i] <= (i >= NUM_BUCKETS) ? 6'(i - NUM_BUCKETS) : hbct_pkg::LINK_NONE;
                prev_reg[i] <= (i + NUM_BUCKETS < NUM_BUFFERS) ? 6'(i + NUM_BUCKETS)
                                                               : hbct_pkg::LINK_NONE;
            end
            // head is the highest entry of the bucket
            for (int b = 0; b < NUM_BUCKETS; b++)
                first_reg[b] <= (b < NUM_BUFFERS)
                    ? 6'(b + NUM_BUCKETS * ((NUM_BUFFERS - 1 - b) / NUM_BUCKETS))
                    : hbct_pkg::LINK_NONE;
        end
        else if (cmd.do_relink)
        begin
            if (rp_ok)
                next_reg[rp[IW-1:0]] <= rn;
            else
                first_reg[steal_reg] <= rn;
            if (rn_ok)
                prev_reg[rn[IW-1:0]] <= rp;
            next_reg[ci] <= th;
            prev_reg[ci] <= hbct_pkg::LINK_NONE;
            if (th < 6'(NUM_BUFFERS) && th != cur_reg)
                prev_reg[th[IW-1:0]] <= cur_reg;
            first_reg[bkt_reg] <= cur_reg;
        end
    end
endmodule

[sv/hashed_buffer_cache_tags.sv]
// hashed_buffer_cache_tags: top level joining controller and datapath
// depends on hbct_pkg, hbct_if, hbct_ctrl, hbct_dp
//
// Each request takes one transaction in and gives one out, one request at a
// time; a new request is taken only once the previous response is accepted.
// A get first reduces the block number modulo NUM_BUCKETS one byte per cycle,
// then walks bucket lists one entry per cycle: tag scan, free scan of its
// bucket, then a steal walk over all buckets. Release, pin and unpin skip the
// hash steps and the walks.
module hashed_buffer_cache_tags #(
    parameter int NUM_BUFFERS = 32,
    parameter int NUM_BUCKETS = 13
) (
    input logic clk,
    input logic rst_n,
    hbct_if.sink   req,
    hbct_if.source rsp
);
    hbct_pkg::cmd_t  cmd;
    hbct_pkg::stat_t st;

    hbct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .st       (st),
        .cmd      (cmd)
    );

    hbct_dp #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .req_type      (req.payload.req_type),
        .device_id     (req.payload.device_id),
        .block_number  (req.payload.block_number),
        .buffer_index  (req.payload.buffer_index),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .granted_index (rsp.payload.granted_index),
        .need_read     (rsp.payload.need_read),
        .status        (rsp.payload.status)
    );
endmodule

[tb/hashed_buffer_cache_tags_test.sv]
// hashed_buffer_cache_tags_test: self-checking bench for the hashed buffer cache tag store
// depends on hbct_pkg, hbct_if and hashed_buffer_cache_tags
module hashed_buffer_cache_tags_test;

    localparam int NBUF = 32;
    localparam int NBKT = 13;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  device_id;
        logic [31:0] block_number;
        logic [4:0]  buffer_index;
    } cache_req_t;

    typedef struct packed {
        logic [4:0] granted_index;
        logic       need_read;
        logic [1:0] status;
    } cache_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    hbct_if #(.payload_t(cache_req_t)) req ();
    hbct_if #(.payload_t(cache_rsp_t)) rsp ();

    hashed_buffer_cache_tags #(.NUM_BUFFERS(NBUF), .NUM_BUCKETS(NBKT)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #5 clk = ~clk;

    // shadow copy of the tag store
    logic [7:0]  sh_dev  [NBUF];
    logic [31:0] sh_blk  [NBUF];
    logic        sh_val  [NBUF];
    logic [7:0]  sh_cnt  [NBUF];
    logic [5:0]  sh_next [NBUF];
    logic [5:0]  sh_prev [NBUF];
    logic [5:0]  sh_head [NBKT];

    cache_req_t  pending_reqs[$];
    bit          drain_before[$];
    cache_rsp_t  expected_rsps[$];
    int          mismatches = 0;
    longint      cycle_no = 0;

    function automatic void shadow_reset();
        for (int b = 0; b < NBKT; b++)
            sh_head[b] = hbct_pkg::LINK_NONE;
        for (int i = 0; i < NBUF; i++)
        begin
            sh_dev[i] = '0;
            sh_blk[i] = '0;
            sh_val[i] = 1'b0;
            sh_cnt[i] = '0;
            sh_next[i] = (i >= NBKT) ? 6'(i - NBKT) : hbct_pkg::LINK_NONE;
            sh_prev[i] = (i + NBKT < NBUF) ? 6'(i + NBKT) : hbct_pkg::LINK_NONE;
            sh_head[i % NBKT] = 6'(i);
        end
    endfunction

    // walk one bucket for a tag match or for a zero count
    function automatic logic [5:0] walk_bucket(int bkt, bit want_free,
                                               logic [7:0] dev, logic [31:0] blk);
        logic [5:0] cur;
        cur = sh_head[bkt];
        for (int s = 0; s < NBUF && cur < NBUF; s++)
        begin
            if (want_free ? (sh_cnt[cur] == 0) : (sh_dev[cur] == dev && sh_blk[cur] == blk))
                return cur;
            cur = sh_next[cur];
        end
        return hbct_pkg::LINK_NONE;
    endfunction

    function automatic void take_entry(logic [5:0] e, cache_req_t r);
        sh_dev[e] = r.device_id;
        sh_blk[e] = r.block_number;
        sh_cnt[e] = 8'd1;
        sh_val[e] = 1'b1;
    endfunction

    // expected response for one accepted request, updates the shadow store
    function automatic cache_rsp_t cache_predict(cache_req_t r);
        cache_rsp_t o;
        int bkt;
        logic [5:0] e, p, n;
        bit found;
        o.granted_index = r.buffer_index;
        o.need_read = 1'b0;
        o.status = hbct_pkg::ST_OK;
        if (r.req_type == hbct_pkg::REQ_GET)
        begin
            bkt = int'(r.block_number % NBKT);
            o.granted_index = '0;
            e = walk_bucket(bkt, 1'b0, r.device_id, r.block_number);
            if (e < NBUF)
            begin
                o.granted_index = e[4:0];
                if (sh_cnt[e] == hbct_pkg::COUNT_MAX)
                    o.status = hbct_pkg::ST_COUNT;
                else
                begin
                    sh_cnt[e]++;
                    o.need_read = ~sh_val[e];
                    sh_val[e] = 1'b1;
                end
            end
            else
            begin
                e = walk_bucket(bkt, 1'b1, '0, '0);
                if (e < NBUF)
                begin
                    take_entry(e, r);
                    o.granted_index = e[4:0];
                    o.need_read = 1'b1;
                end
                else
                begin
                    found = 1'b0;
                    for (int b = 0; b < NBKT && !found; b++)
                    begin
                        e = walk_bucket(b, 1'b1, '0, '0);
                        if (e < NBUF)
                        begin
                            // unlink from its bucket, push on head of target
                            p = sh_prev[e];
                            n = sh_next[e];
                            if (p < NBUF) sh_next[p] = n;
                            else sh_head[b] = n;
                            if (n < NBUF) sh_prev[n] = p;
                            n = sh_head[bkt];
                            sh_next[e] = n;
                            sh_prev[e] = hbct_pkg::LINK_NONE;
                            if (n < NBUF) sh_prev[n] = e;
                            sh_head[bkt] = e;
                            take_entry(e, r);
                            o.granted_index = e[4:0];
                            o.need_read = 1'b1;
                            found = 1'b1;
                        end
                    end
                    if (!found)
                        o.status = hbct_pkg::ST_NO_FREE;
                end
            end
        end
        else if (r.buffer_index >= NBUF)
            o.status = hbct_pkg::ST_RANGE;
        else if (r.req_type == hbct_pkg::REQ_PIN)
        begin
            if (sh_cnt[r.buffer_index] == hbct_pkg::COUNT_MAX) o.status = hbct_pkg::ST_COUNT;
            else sh_cnt[r.buffer_index]++;
        end
        else
        begin
            if (sh_cnt[r.buffer_index] == 0) o.status = hbct_pkg::ST_COUNT;
            else sh_cnt[r.buffer_index]--;
        end
        return o;
    endfunction

    function automatic bit idle_now();
        // quiet stretch with no idling in the middle of the run
        if (cycle_no > 3000 && cycle_no < 12000)
            return 1'b0;
        return $urandom_range(99) < 13;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.payload <= '0;
        end
        else
        begin
            cycle_no <= cycle_no + 1;
            if (req.valid && req.ready)
                expected_rsps.push_back(cache_predict(req.payload));
            if (!req.valid || req.ready)
            begin
                if (pending_reqs.size() > 0 && !idle_now() &&
                    !(drain_before[0] && (expected_rsps.size() > 0 ||
                                          (req.valid && req.ready))))
                begin
                    req.valid <= 1'b1;
                    req.payload <= pending_reqs.pop_front();
                    void'(drain_before.pop_front());
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // response monitor and ready generation
    always @(posedge clk or negedge rst_n)
    begin
        cache_rsp_t want;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: %p", rsp.payload);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.payload.granted_index !== want.granted_index ||
                        rsp.payload.need_read !== want.need_read ||
                        rsp.payload.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, actual %p", want, rsp.payload);
                    end
                end
            end
            rsp.ready <= !idle_now();
        end
    end

    task automatic add_req(logic [1:0] kind, logic [7:0] dev, logic [31:0] blk,
                           logic [4:0] idx, bit drain = 1'b0);
        cache_req_t r;
        r.req_type = kind;
        r.device_id = dev;
        r.block_number = blk;
        r.buffer_index = idx;
        pending_reqs.push_back(r);
        drain_before.push_back(drain);
    endtask

    initial
    begin
        int pick;
        logic [31:0] blk;
        logic [7:0] dev;
        shadow_reset();
        req.valid = 1'b0;
        req.payload = '0;
        rsp.ready = 1'b0;

        // directed: reset tags, hits, extremes, every request kind
        add_req(hbct_pkg::REQ_GET, 8'd0, 32'd0, 5'd0);
        add_req(hbct_pkg::REQ_GET, 8'd0, 32'd0, 5'd31);
        add_req(hbct_pkg::REQ_GET, 8'hff, 32'hffff_ffff, 5'd0);
        add_req(hbct_pkg::REQ_GET, 8'd1, 32'd13, 5'd0);
        add_req(hbct_pkg::REQ_RELEASE, 8'd0, 32'd0, 5'd0);
        add_req(hbct_pkg::REQ_UNPIN, 8'd0, 32'd0, 5'd31);
        add_req(hbct_pkg::REQ_PIN, 8'd0, 32'd0, 5'd31);
        add_req(hbct_pkg::REQ_UNPIN, 8'd0, 32'd0, 5'd31);
        add_req(hbct_pkg::REQ_PIN, 8'hff, 32'hffff_ffff, 5'd5);
        add_req(hbct_pkg::REQ_RELEASE, 8'hff, 32'hffff_ffff, 5'd5);
        // bucket 12 holds two entries, the third distinct get steals
        add_req(hbct_pkg::REQ_GET, 8'd2, 32'd12, 5'd0);
        add_req(hbct_pkg::REQ_GET, 8'd2, 32'd25, 5'd0);
        add_req(hbct_pkg::REQ_GET, 8'd2, 32'd38, 5'd0);
        add_req(hbct_pkg::REQ_GET, 8'd3, 32'd38, 5'd0);
        add_req(hbct_pkg::REQ_GET, 8'd2, 32'd38, 5'd0);

        // fill every entry, then no free buffer, then release all
        for (int i = 0; i < 34; i++)
            add_req(hbct_pkg::REQ_GET, 8'd9, 32'(1000 + i), 5'(i));
        for (int i = 0; i < NBUF; i++)
            add_req(hbct_pkg::REQ_RELEASE, 8'd0, 32'd0, 5'(i), i == 0);
        for (int i = 0; i < NBUF; i++)
            add_req(hbct_pkg::REQ_UNPIN, 8'd0, 32'd0, 5'(i));

        // count overflow on one entry, which then stays pinned at the top
        for (int i = 0; i < 256; i++)
            add_req(hbct_pkg::REQ_PIN, 8'd0, 32'd0, 5'd7);

        // random mix, gets mostly from a small pool of blocks
        for (int i = 0; i < 180; i++)
        begin
            pick = $urandom_range(99);
            blk = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(60));
            dev = ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(3));
            if (pick < 50)
                add_req(hbct_pkg::REQ_GET, dev, blk, 5'($urandom()));
            else if (pick < 75)
                add_req(hbct_pkg::REQ_RELEASE, dev, blk, 5'($urandom()));
            else if (pick < 87)
                add_req(hbct_pkg::REQ_PIN, dev, blk, 5'($urandom()));
            else
                add_req(hbct_pkg::REQ_UNPIN, dev, blk, 5'($urandom()), i == 100);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the queue to empty and every response to come back
        do
            @(posedge clk);
        while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("hashed_buffer_cache_tags_test: done, clean");
        else
            $display("hashed_buffer_cache_tags_test: done, errors");
        $finish;
    end

    initial
    begin
        #50000000;
        $display("hashed_buffer_cache_tags_test: done, errors");
        $finish;
    end

endmodule

[files.f]
sv/hbct_pkg.sv
sv/hbct_if.sv
sv/hbct_ctrl.sv
sv/hbct_dp.sv
sv/hashed_buffer_cache_tags.sv
tb/hashed_buffer_cache_tags_test.sv
